FILE: rtl/falru_pkg.sv
// shared constants and types for the fully associative lru tag store
package falru_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W = 32;
  localparam int TAG_W = 32;
  localparam int STAMP_W = 32;
  localparam int SHIFT_W = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [SHIFT_W-1:0] TAG_SHIFT_RESET = SHIFT_W'(14);
  localparam logic REG_TAG_SHIFT = 1'b0;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] now;
    logic               hit;
    logic               zero_found;
    logic [STAMP_W-1:0] best;
    logic [IDX_W-1:0]   idx;
  } tok_t;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] now;
  } wb_t;

endpackage

FILE: rtl/falru_access_if.sv
// access channel: address and timestamp of one lookup
interface falru_access_if import falru_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   address;
  logic [STAMP_W-1:0]  access_time;

  modport source (output valid, output address, output access_time, input ready);
  modport sink (input valid, input address, input access_time, output ready);
endinterface

FILE: rtl/falru_result_if.sv
// result channel: hit flag of one lookup
interface falru_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

FILE: rtl/falru_cell.sv
// one tag store cell: holds a tag and stamp, folds them into the passing search token
module falru_cell import falru_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_index,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  input  wb_t              wb
);

  logic [TAG_W-1:0]   tag;
  logic [STAMP_W-1:0] stamp;
  tok_t               tok_next;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.hit) begin
      if (tag == tok_in.tag) begin
        tok_next.hit = 1'b1;
        tok_next.idx = cell_index;
      end else if (!tok_in.zero_found) begin
        if (tag == '0) begin
          tok_next.zero_found = 1'b1;
          tok_next.idx = cell_index;
        end else if (stamp < tok_in.best) begin
          tok_next.best = stamp;
          tok_next.idx = cell_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
      stamp <= '0;
    end else if (wb.valid && wb.idx == cell_index) begin
      stamp <= wb.now;
      if (!wb.hit) begin
        tag <= wb.tag;
      end
    end
  end

endmodule

FILE: rtl/fully_associative_lru_tag_store_core.sv
// top level of the fully associative lru tag store: cell chain, write-back, result register and tag shift register
// Each access walks a search token down a chain of ENTRIES cells, one cell per cycle; the
// token gathers the first matching cell, the first invalid (tag zero) cell and the oldest
// stamp below the access time. When it leaves the last cell the chosen cell is written in
// the same cycle and the hit flag is loaded into the output register, or held pending
// while that register still holds a result that the receiver has not taken. The next
// access is accepted in the cycle after the result is loaded, so a new access is not
// accepted before the previous one has passed the whole chain, and it waits longer while a
// finished result waits behind an earlier one that the receiver has not yet taken.
// The tag is the address shifted right by tag_shift (register 0, byte address 0, reset 14).
// Reset clears every cell at once; no clearing pass is needed.
module fully_associative_lru_tag_store_core import falru_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  falru_access_if.sink       access,
  falru_result_if.source     result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [SHIFT_W-1:0] tag_shift;
  logic               busy;
  logic               pend_valid;
  logic               pend_hit;
  logic               out_valid;
  logic               out_hit;
  logic               out_free;
  logic               accept;
  tok_t               chain [ENTRIES+1];
  logic [ENTRIES-1:0] chain_valid;
  wb_t                wb;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TAG_SHIFT) ? PDATA_W'(tag_shift) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_shift <= TAG_SHIFT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TAG_SHIFT) begin
      tag_shift <= pwdata[SHIFT_W-1:0];
    end
  end

  assign access.ready = !busy;
  assign accept = access.valid && !busy;

  always_comb begin
    chain[0].valid = accept;
    chain[0].tag = TAG_W'(access.address >> tag_shift);
    chain[0].now = access.access_time;
    chain[0].hit = 1'b0;
    chain[0].zero_found = 1'b0;
    chain[0].best = access.access_time;
    chain[0].idx = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    falru_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1]),
      .wb         (wb)
    );
    assign chain_valid[i] = chain[i+1].valid;
  end

  always_comb begin
    wb.valid = chain[ENTRIES].valid;
    wb.hit = chain[ENTRIES].hit;
    wb.idx = chain[ENTRIES].idx;
    wb.tag = chain[ENTRIES].tag;
    wb.now = chain[ENTRIES].now;
  end

  assign out_free = !out_valid || result.ready;
  assign result.valid = out_valid;
  assign result.hit = out_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (pend_valid && out_free) begin
        out_valid <= 1'b1;
        out_hit <= pend_hit;
        pend_valid <= 1'b0;
        busy <= 1'b0;
      end else if (wb.valid && out_free) begin
        out_valid <= 1'b1;
        out_hit <= wb.hit;
        busy <= 1'b0;
      end else begin
        if (wb.valid) begin
          pend_valid <= 1'b1;
          pend_hit <= wb.hit;
        end
        if (out_valid && result.ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // at most one search token in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(chain_valid) <= 1)
    else $error("more than one search token in the cell chain");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    accept |-> chain_valid == '0 && !pend_valid)
    else $error("transaction accepted while a search is still in flight");

  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    wb.valid |-> busy && !pend_valid)
    else $error("write-back without an access in progress");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy && out_valid)
    else $error("pending result while the output register is free or block idle");

endmodule
